// ===== sv/mtmr_pkg.sv =====
// Package for the multi-slot one-shot / periodic timer core.
// Holds field widths, command and result codes, FSM states and shared structs.
// No dependencies.
package mtmr_pkg;

    // Default number of timer slots
    localparam int NUM_TIMERS_DEF = 16;

    // Field widths fixed by the request / result format
    localparam int TIME_W = 64;
    localparam int ID_W   = 4;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // One input request
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] start_delay;
        logic [TIME_W-1:0] repeat_period;
        logic [TIME_W-1:0] now_ms;
    } t_req;

    // One result
    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] timer_id_res;
        logic            active;
        logic            last;
    } t_result;

    // Result push from the sequencer to the output register
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

// ===== sv/mtmr_if.sv =====
// Valid/ready channel interfaces for the timer core: request and result channels.
// Depends on mtmr_pkg for the field widths.

// Request channel
interface mtmr_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [mtmr_pkg::CMD_W-1:0]     command;
    logic [mtmr_pkg::ID_W-1:0]      timer_id;
    logic [mtmr_pkg::TIME_W-1:0]    start_delay;
    logic [mtmr_pkg::TIME_W-1:0]    repeat_period;
    logic [mtmr_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, command, timer_id, start_delay, repeat_period, now_ms,
                    input ready);
    modport sink   (input valid, command, timer_id, start_delay, repeat_period, now_ms,
                    output ready);
endinterface

// Result channel
interface mtmr_res_if;
    logic                           valid;
    logic                           ready;
    logic [mtmr_pkg::KIND_W-1:0]    kind;
    logic [mtmr_pkg::ID_W-1:0]      timer_id_res;
    logic                           active;
    logic                           last;

    modport source (output valid, kind, timer_id_res, active, last, input ready);
    modport sink   (input valid, kind, timer_id_res, active, last, output ready);
endinterface

// ===== sv/mtmr_ram.sv =====
// Simple dual-port RAM, one write and one registered read port, read enable.
// Holds deadline and period per timer slot. No dependencies.
module mtmr_ram #(
    parameter  int DEPTH  = 16,
    parameter  int WIDTH  = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; data holds while the read is not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mtmr_seq.sv =====
// Request sequencer for the timer core: armed flags, tick scan, read-modify-write.
// Depends on mtmr_pkg and instantiates mtmr_ram.
module mtmr_seq #(
    parameter int NUM_TIMERS = mtmr_pkg::NUM_TIMERS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  mtmr_pkg::t_req  i_req,
    output logic            o_req_ready,
    input  logic            i_can_push,
    output mtmr_pkg::t_push o_push
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW     = mtmr_pkg::TIME_W;
    localparam int WORD_W = 2 * TW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    mtmr_pkg::t_state        r_state, n_state;
    logic [IDX_W-1:0]        r_eval_idx, n_eval_idx;
    logic [TW-1:0]           r_now, n_now;
    logic [NUM_TIMERS-1:0]   r_armed, n_armed;

    logic                    req_fire;
    logic                    in_range;
    logic [IDX_W-1:0]        id_idx;
    logic [8:0]              id_ext;
    mtmr_pkg::t_cmd          cmd;
    logic                    fire;
    logic                    advance;
    logic [TW-1:0]           slot_dl;
    logic [TW-1:0]           slot_per;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [WORD_W-1:0]       rd_data;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [WORD_W-1:0]       wr_data;

    // Deadline (upper half) and period (lower half) per slot
    mtmr_ram #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Request decode
    assign cmd      = mtmr_pkg::t_cmd'(i_req.command);
    assign req_fire = i_req_valid && o_req_ready;
    assign id_ext   = 9'(i_req.timer_id);
    assign in_range = id_ext < 9'(NUM_TIMERS);
    assign id_idx   = IDX_W'(i_req.timer_id);

    // Slot under evaluation during a tick scan
    assign slot_dl  = rd_data[WORD_W-1:TW];
    assign slot_per = rd_data[TW-1:0];
    assign fire     = r_armed[r_eval_idx] && (r_now >= slot_dl);
    // Hold the slot while a fired result cannot be pushed
    assign advance  = !fire || i_can_push;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtmr_pkg::S_IDLE: begin
                if (req_fire && (cmd == mtmr_pkg::CMD_TICK)) begin
                    n_state = mtmr_pkg::S_SCAN;
                end
            end
            mtmr_pkg::S_SCAN: begin
                if (advance && (r_eval_idx == LAST_IDX)) begin
                    n_state = mtmr_pkg::S_DONE;
                end
            end
            mtmr_pkg::S_DONE: begin
                if (i_can_push) begin
                    n_state = mtmr_pkg::S_IDLE;
                end
            end
            default: n_state = mtmr_pkg::S_IDLE;
        endcase
    end

    // Outputs, memory accesses and slot updates
    always_comb begin
        o_req_ready = (r_state == mtmr_pkg::S_IDLE) && i_can_push;
        o_push      = '0;
        rd_en       = 1'b0;
        rd_addr     = r_eval_idx + 1'b1;
        wr_en       = 1'b0;
        wr_addr     = r_eval_idx;
        wr_data     = {r_now + slot_per, slot_per};
        n_armed     = r_armed;
        n_eval_idx  = r_eval_idx;
        n_now       = r_now;
        case (r_state)
            mtmr_pkg::S_IDLE: begin
                if (req_fire) begin
                    case (cmd)
                        mtmr_pkg::CMD_START: begin
                            o_push.valid            = 1'b1;
                            o_push.res.kind         = mtmr_pkg::KIND_DONE;
                            o_push.res.timer_id_res = i_req.timer_id;
                            o_push.res.last         = 1'b1;
                            if (in_range) begin
                                wr_en           = 1'b1;
                                wr_addr         = id_idx;
                                wr_data         = {i_req.now_ms + i_req.start_delay,
                                                   i_req.repeat_period};
                                n_armed[id_idx] = 1'b1;
                            end
                        end
                        mtmr_pkg::CMD_STOP: begin
                            o_push.valid            = 1'b1;
                            o_push.res.kind         = mtmr_pkg::KIND_DONE;
                            o_push.res.timer_id_res = i_req.timer_id;
                            o_push.res.last         = 1'b1;
                            if (in_range) begin
                                n_armed[id_idx] = 1'b0;
                            end
                        end
                        mtmr_pkg::CMD_QUERY: begin
                            o_push.valid            = 1'b1;
                            o_push.res.kind         = mtmr_pkg::KIND_QUERY;
                            o_push.res.timer_id_res = i_req.timer_id;
                            o_push.res.active       = in_range && r_armed[id_idx];
                            o_push.res.last         = 1'b1;
                        end
                        mtmr_pkg::CMD_TICK: begin
                            // Start the scan at slot 0
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            n_eval_idx = '0;
                            n_now      = i_req.now_ms;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mtmr_pkg::S_SCAN: begin
                if (advance) begin
                    if (fire) begin
                        o_push.valid            = 1'b1;
                        o_push.res.kind         = mtmr_pkg::KIND_FIRED;
                        o_push.res.timer_id_res = mtmr_pkg::ID_W'(r_eval_idx);
                        // Periodic: rearm at now + period; one-shot: disarm
                        if (slot_per != '0) begin
                            wr_en = 1'b1;
                        end else begin
                            n_armed[r_eval_idx] = 1'b0;
                        end
                    end
                    if (r_eval_idx != LAST_IDX) begin
                        rd_en      = 1'b1;
                        n_eval_idx = r_eval_idx + 1'b1;
                    end
                end
            end
            mtmr_pkg::S_DONE: begin
                if (i_can_push) begin
                    o_push.valid    = 1'b1;
                    o_push.res.kind = mtmr_pkg::KIND_DONE;
                    o_push.res.last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mtmr_pkg::S_IDLE;
            r_armed    <= '0;
            r_eval_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_armed    <= n_armed;
            r_eval_idx <= n_eval_idx;
        end
    end

    // Tick time latch
    always_ff @(posedge i_clk) begin
        r_now <= n_now;
    end

endmodule

// ===== sv/multi_slot_oneshot_periodic_timer_core.sv =====
// Top level of the multi-slot one-shot / periodic timer core.
// Depends on mtmr_pkg, mtmr_if and mtmr_seq.

// A bank of NUM_TIMERS timer slots addressed by index. Start, stop and query
// requests each give one result. A tick request scans all slots in index
// order through the single read port of the slot RAM, one slot per cycle
// unless the result channel stalls on a fired result, which holds the slot;
// it gives one fired result per expiring slot and a final done result marked
// last. Results pass through an output register; a new request is taken only
// in the idle state and when that register is empty or its result is taken in
// the same cycle.
// Slot deadlines and periods sit in RAM; the armed flags are flip-flops that
// reset clears, so no RAM clearing pass is needed.
module multi_slot_oneshot_periodic_timer_core #(
    parameter int NUM_TIMERS = mtmr_pkg::NUM_TIMERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtmr_cmd_if.sink   i_cmd,
    mtmr_res_if.source o_res
);

    mtmr_pkg::t_req    req;
    mtmr_pkg::t_push   push;
    mtmr_pkg::t_result r_res;
    logic              r_res_valid;
    logic              can_push;
    logic              req_ready;

    // Request payload
    assign req.command       = i_cmd.command;
    assign req.timer_id      = i_cmd.timer_id;
    assign req.start_delay   = i_cmd.start_delay;
    assign req.repeat_period = i_cmd.repeat_period;
    assign req.now_ms        = i_cmd.now_ms;
    assign i_cmd.ready       = req_ready;

    mtmr_seq #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_cmd.valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .i_can_push  (can_push),
        .o_push      (push)
    );

    // Output register: free when empty or being taken this cycle
    assign can_push = !r_res_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (can_push) begin
            r_res_valid <= push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_push && push.valid) begin
            r_res <= push.res;
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.timer_id_res = r_res.timer_id_res;
    assign o_res.active       = r_res.active;
    assign o_res.last         = r_res.last;

endmodule
